// ===== hw/rtl/plr_pkg.sv =====
package plr_pkg;

    // Sample and accumulator widths that the port list fixes.
    localparam int SAMPLE_BITS = 16;
    localparam int PEAK_W      = SAMPLE_BITS - 1;
    localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W       = 43;
    localparam int X_W         = SUM_W + 1;
    localparam int ROOT_W      = X_W / 2;
    localparam int RREM_W      = ROOT_W + 2;
    localparam int CH_W        = 3;
    localparam int CFG_W       = 4;
    localparam int RMS_W       = 16;
    localparam int STEP_W      = 6;

    // Reset value of the channel count register.
    localparam logic [CFG_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Result kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // One classified sample as it travels from the front to the back.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [CH_W-1:0]        channel;
        logic                   eob;
        logic                   in_range;
        logic                   frame_done;
        logic [CFG_W-1:0]       nch;
        logic [SQ_W-1:0]        square;
    } t_cmd;

    // One result word.
    typedef struct packed {
        logic                   kind;
        logic [SAMPLE_BITS-1:0] sample_out;
        logic [CH_W-1:0]        report_channel;
        logic [PEAK_W-1:0]      peak_level;
        logic [RMS_W-1:0]       rms_level;
        logic                   last;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_START,
        BK_WAIT,
        BK_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        RMS_IDLE,
        RMS_DIV,
        RMS_ROOT,
        RMS_DONE
    } t_rms_state;

endpackage

// ===== hw/rtl/plr_front.sv =====
module plr_front #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [plr_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_push,
    input  logic [plr_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [plr_pkg::CH_W-1:0]       i_channel,
    input  logic                           i_end_of_block,
    output logic                           o_q_push,
    output plr_pkg::t_cmd                  o_q_data
);
    import plr_pkg::*;

    logic [CFG_W-1:0]       r_channel_count;
    logic [CFG_W-1:0]       nch;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_W-1:0]        square;
    logic                   in_range;

    // The channel count register is always ready for a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHANNEL_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_channel_count <= i_cfg_data;
        end
    end

    // Clamp the programmed count into the range of channels the block has.
    always_comb begin
        priority if (r_channel_count == '0) begin
            nch = CFG_W'(1);
        end else if (r_channel_count > CFG_W'(MAX_CHANNELS)) begin
            nch = CFG_W'(MAX_CHANNELS);
        end else begin
            nch = r_channel_count;
        end
    end

    // Magnitude and square of the sample; the most negative code squares to 2^30.
    assign mag    = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;
    assign square = SQ_W'(mag) * SQ_W'(mag);

    assign in_range = ({1'b0, i_channel} < nch);

    // Classify the word and hand it to the queue.
    assign o_q_push = i_push;
    always_comb begin
        o_q_data.sample     = i_sample;
        o_q_data.channel    = i_channel;
        o_q_data.eob        = i_end_of_block;
        o_q_data.in_range   = in_range;
        o_q_data.frame_done = in_range &&
                              (({1'b0, i_channel} == nch - CFG_W'(1)) || i_end_of_block);
        o_q_data.nch        = nch;
        o_q_data.square     = square;
    end

endmodule

// ===== hw/rtl/plr_queue.sv =====
module plr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  plr_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output plr_pkg::t_cmd o_data
);
    import plr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_entry[r_rd_ptr];

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/plr_rms_unit.sv =====
module plr_rms_unit #(
    parameter int FC_W = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [plr_pkg::SUM_W-1:0]   i_sum,
    input  logic [FC_W-1:0]             i_frames,
    output logic                        o_done,
    output logic [plr_pkg::RMS_W-1:0]   o_rms
);
    import plr_pkg::*;

    t_rms_state        r_state;
    t_rms_state        n_state;
    logic [STEP_W-1:0] r_step;
    logic [X_W-1:0]    r_x;
    logic [FC_W-1:0]   r_div;
    logic [FC_W-1:0]   r_drem;
    logic [RREM_W-1:0] r_rrem;
    logic [ROOT_W-1:0] r_root;
    logic              last_step;

    // Division step: shift in one dividend bit and try a subtract.
    logic [FC_W:0]     drem_sh;
    logic              div_ge;
    logic [FC_W:0]     drem_sub;

    // Root step: bring down two bits and try the odd trial value.
    logic [RREM_W+1:0] rrem_sh;
    logic [RREM_W+1:0] trial;
    logic              root_ge;
    logic [RREM_W+1:0] rrem_sub;

    assign drem_sh  = {r_drem, r_x[SUM_W-1]};
    assign div_ge   = (drem_sh >= {1'b0, r_div});
    assign drem_sub = drem_sh - {1'b0, r_div};

    assign rrem_sh  = {r_rrem, r_x[X_W-1:X_W-2]};
    assign trial    = (RREM_W+2)'({r_root, 2'b01});
    assign root_ge  = (rrem_sh >= trial);
    assign rrem_sub = rrem_sh - trial;

    always_comb begin
        unique case (r_state)
            RMS_DIV:  last_step = (r_step == STEP_W'(SUM_W - 1));
            RMS_ROOT: last_step = (r_step == STEP_W'(ROOT_W - 1));
            default:  last_step = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RMS_IDLE, RMS_DONE: begin
                if (i_start) begin
                    n_state = (i_frames == '0) ? RMS_DONE : RMS_DIV;
                end
            end
            RMS_DIV: begin
                if (last_step) begin
                    n_state = RMS_ROOT;
                end
            end
            RMS_ROOT: begin
                if (last_step) begin
                    n_state = RMS_DONE;
                end
            end
            default: n_state = RMS_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_done = (r_state == RMS_DONE);
        o_rms  = r_root[RMS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RMS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (i_start || last_step) begin
                r_step <= '0;
            end else if (r_state == RMS_DIV || r_state == RMS_ROOT) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // Quotient forms in the low bits of r_x, then the root consumes it two bits a step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= {1'b0, i_sum};
            r_div  <= i_frames;
            r_drem <= '0;
            r_rrem <= '0;
            r_root <= '0;
        end else if (r_state == RMS_DIV) begin
            r_drem           <= div_ge ? drem_sub[FC_W-1:0] : drem_sh[FC_W-1:0];
            r_x[SUM_W-1:0]   <= {r_x[SUM_W-2:0], div_ge};
        end else if (r_state == RMS_ROOT) begin
            r_rrem <= root_ge ? rrem_sub[RREM_W-1:0] : rrem_sh[RREM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], root_ge};
            r_x    <= {r_x[X_W-3:0], 2'b00};
        end
    end

endmodule

// ===== hw/rtl/plr_back.sv =====
module plr_back #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_FRAMES   = 4096,
    parameter int FC_W         = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  plr_pkg::t_cmd    i_q_data,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_valid,
    output plr_pkg::t_result o_result
);
    import plr_pkg::*;

    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    t_back_state         r_state;
    t_back_state         n_state;
    logic [PEAK_W-1:0]   r_peak [MAX_CHANNELS];
    logic [SUM_W-1:0]    r_sum  [MAX_CHANNELS];
    logic [FC_W-1:0]     r_frames;
    logic [CH_W-1:0]     r_idx;
    logic [CFG_W-1:0]    r_nch;
    logic                r_out_valid;
    t_result             r_out;

    logic                can_emit;
    logic                fire;
    logic                meter_en;
    logic                emit_report;
    logic                rms_start;
    logic                rms_done;
    logic [RMS_W-1:0]    rms_value;
    logic                report_last;
    logic [CH_IDX_W-1:0] addr;
    logic [PEAK_W-1:0]   peak_rd;
    logic [SUM_W-1:0]    sum_rd;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;
    logic                peak_up;

    // The output register takes a word when it is empty or being drained.
    assign can_emit    = !r_out_valid || i_pop;
    assign report_last = (r_idx == CH_W'(r_nch - CFG_W'(1)));

    // One store address: the sample's channel while metering, the report index after.
    assign addr    = (r_state == BK_IDLE) ? i_q_data.channel[CH_IDX_W-1:0]
                                          : r_idx[CH_IDX_W-1:0];
    assign peak_rd = r_peak[addr];
    assign sum_rd  = r_sum[addr];

    // Saturating accumulate and signed peak update.
    assign sum_add = {1'b0, sum_rd} + (SUM_W+1)'(i_q_data.square);
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign peak_up = !i_q_data.sample[SAMPLE_BITS-1] &&
                     (i_q_data.sample[PEAK_W-1:0] > peak_rd);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && can_emit && i_q_data.eob) begin
                    n_state = BK_START;
                end
            end
            BK_START: n_state = BK_WAIT;
            BK_WAIT: begin
                if (rms_done) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (can_emit) begin
                    n_state = report_last ? BK_IDLE : BK_START;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        fire        = 1'b0;
        emit_report = 1'b0;
        rms_start   = 1'b0;
        unique case (r_state)
            BK_IDLE:  fire        = !i_q_empty && can_emit;
            BK_START: rms_start   = 1'b1;
            BK_EMIT:  emit_report = can_emit;
            default: begin
                fire = 1'b0;
            end
        endcase
    end

    assign o_q_pop  = fire;
    assign meter_en = fire && i_q_data.in_range;

    plr_rms_unit #(
        .FC_W(FC_W)
    ) u_rms (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (rms_start),
        .i_sum    (sum_rd),
        .i_frames (r_frames),
        .o_done   (rms_done),
        .o_rms    (rms_value)
    );

    // Sequencer and per-channel level state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_frames <= '0;
            r_idx    <= '0;
            r_nch    <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_peak[i] <= '0;
                r_sum[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (meter_en) begin
                r_sum[addr] <= sum_sat;
                if (peak_up) begin
                    r_peak[addr] <= i_q_data.sample[PEAK_W-1:0];
                end
                if (i_q_data.frame_done && (r_frames < FC_W'(MAX_FRAMES))) begin
                    r_frames <= r_frames + FC_W'(1);
                end
            end
            if (fire) begin
                r_idx <= '0;
                r_nch <= i_q_data.nch;
            end
            if (emit_report) begin
                r_sum[addr] <= '0;
                r_idx       <= r_idx + CH_W'(1);
                if (report_last) begin
                    r_frames <= '0;
                end
            end
        end
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire || emit_report) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.kind           <= KIND_SAMPLE;
            r_out.sample_out     <= i_q_data.sample;
            r_out.report_channel <= '0;
            r_out.peak_level     <= '0;
            r_out.rms_level      <= '0;
            r_out.last           <= !i_q_data.eob;
        end else if (emit_report) begin
            r_out.kind           <= KIND_REPORT;
            r_out.sample_out     <= '0;
            r_out.report_channel <= r_idx;
            r_out.peak_level     <= peak_rd;
            r_out.rms_level      <= rms_value;
            r_out.last           <= report_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/peak_rms_level_meter.sv =====
// Peak and RMS level meter for interleaved signed Q1.15 audio. Every sample word
// pushed in comes back out as a passthrough word; per channel the block keeps a
// peak since reset and a sum of squares over the current block. A sample flagged
// end_of_block is metered first, and is then followed by one report word per
// active channel, in channel order, carrying the peak and floor(sqrt(sum/frames)),
// after which the sums and the frame count clear. A two-word queue sits between
// the input side and the metering sequencer, so samples are taken while a result
// waits. The sequencer takes a new plain sample whenever its output can take a
// word. Each report runs one shared unit through a restoring divide, one
// quotient bit a cycle, and a square root, two bits a cycle, so an end-of-block
// sample holds off the next sample until every active channel has reported. The
// channel_count register takes 0 as 1 and clamps values above MAX_CHANNELS.
module peak_rms_level_meter #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_FRAMES   = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [plr_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [plr_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [plr_pkg::CH_W-1:0]        i_channel,
    input  logic                            i_end_of_block,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_kind,
    output logic [plr_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic [plr_pkg::CH_W-1:0]        o_report_channel,
    output logic [plr_pkg::PEAK_W-1:0]      o_peak_level,
    output logic [plr_pkg::RMS_W-1:0]       o_rms_level,
    output logic                            o_last
);
    import plr_pkg::*;

    localparam int FC_W = $clog2(MAX_FRAMES + 1);

    logic    q_push;
    t_cmd    q_in;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_cmd    q_out;
    logic    out_valid;
    t_result result;

    plr_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_sample       (i_sample),
        .i_channel      (i_channel),
        .i_end_of_block (i_end_of_block),
        .o_q_push       (q_push),
        .o_q_data       (q_in)
    );

    plr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    plr_back #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_FRAMES  (MAX_FRAMES),
        .FC_W        (FC_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_valid   (out_valid),
        .o_result  (result)
    );

    // Queue-style status toward both neighbors.
    assign full  = q_full;
    assign empty = !out_valid;

    assign o_kind           = result.kind;
    assign o_sample_out     = result.sample_out;
    assign o_report_channel = result.report_channel;
    assign o_peak_level     = result.peak_level;
    assign o_rms_level      = result.rms_level;
    assign o_last           = result.last;

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plr_pkg::*;

    localparam int METER_CHANNELS = 8;
    localparam int FRAME_CAP      = 4096;
    localparam int SETTLE_CYCLES  = 16;
    localparam int STALL_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 100;
    localparam int LONG_LENGTH    = 40;
    localparam int PHASE_ITEMS    = 34;
    localparam longint unsigned SUM_CEIL = (64'd1 << SUM_W) - 64'd1;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_CONFIG,
        OP_DRAIN
    } t_stim_op;

    typedef struct packed {
        t_stim_op               op;
        logic [SAMPLE_BITS-1:0] sample;
        logic [CH_W-1:0]        channel;
        logic                   eob;
        logic [CFG_W-1:0]       cfg;
        logic                   calm;
    } t_stim;

    // Clock, reset and every input of the block start at known values.
    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_valid    = 1'b0;
    logic [CFG_W-1:0]       i_cfg_data     = '0;
    logic                   push           = 1'b0;
    logic [SAMPLE_BITS-1:0] i_sample       = '0;
    logic [CH_W-1:0]        i_channel      = '0;
    logic                   i_end_of_block = 1'b0;
    logic                   pop            = 1'b0;
    logic                   o_cfg_ready;
    logic                   full;
    logic                   empty;
    logic                   o_kind;
    logic [SAMPLE_BITS-1:0] o_sample_out;
    logic [CH_W-1:0]        o_report_channel;
    logic [PEAK_W-1:0]      o_peak_level;
    logic [RMS_W-1:0]       o_rms_level;
    logic                   o_last;

    // Pending stimulus and the words the meter is expected to return.
    t_stim   stim_q[$];
    t_result level_words[$];

    // Predictor state: channel count, per-channel peaks and square sums.
    logic [CFG_W-1:0]  chan_cfg = CHANNEL_COUNT_RESET;
    logic [PEAK_W-1:0] peak_hold[METER_CHANNELS];
    longint unsigned   sq_sum[METER_CHANNELS];
    int unsigned       frames_seen = 0;

    // Handshake bookkeeping shared between the driver and the monitor.
    logic push_taken  = 1'b0;
    logic cfg_taken   = 1'b0;
    logic calm_run    = 1'b0;
    int   settle_left = 0;
    int   quiet_count = 0;
    int   mismatches  = 0;
    int   samples_metered = 0;
    int   reports_seen    = 0;
    int   cfg_writes      = 0;

    peak_rms_level_meter #(
        .MAX_CHANNELS(METER_CHANNELS),
        .MAX_FRAMES  (FRAME_CAP)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_sample        (i_sample),
        .i_channel       (i_channel),
        .i_end_of_block  (i_end_of_block),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_sample_out    (o_sample_out),
        .o_report_channel(o_report_channel),
        .o_peak_level    (o_peak_level),
        .o_rms_level     (o_rms_level),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Active channel count: zero acts as one, large values clamp to the maximum.
    function automatic int unsigned active_count(input logic [CFG_W-1:0] cfg);
        int unsigned c;
        c = 32'(cfg);
        if (c == 0) begin
            c = 1;
        end
        if (c > METER_CHANNELS) begin
            c = METER_CHANNELS;
        end
        return c;
    endfunction

    // Floor of the square root, built up one result bit at a time.
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 22; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        int unsigned pick;
        logic [SAMPLE_BITS-1:0] v;
        pick = $urandom_range(9);
        if (pick == 0) begin
            v = 16'h7FFF;
        end else if (pick == 1) begin
            v = 16'h8000;
        end else if (pick == 2) begin
            v = SAMPLE_BITS'($urandom_range(15));
            if ($urandom_range(1) == 1) begin
                v = -v;
            end
        end else begin
            v = SAMPLE_BITS'($urandom());
        end
        return v;
    endfunction

    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] smp, input int unsigned ch,
                                input logic eob, input logic calm);
        t_stim s;
        s = '0;
        s.op      = OP_SAMPLE;
        s.sample  = smp;
        s.channel = ch[CH_W-1:0];
        s.eob     = eob;
        s.calm    = calm;
        stim_q.push_back(s);
    endtask

    // A channel count write always follows a full drain of the result side.
    task automatic queue_config(input logic [CFG_W-1:0] value);
        t_stim s;
        s = '0;
        s.op = OP_DRAIN;
        stim_q.push_back(s);
        s.op  = OP_CONFIG;
        s.cfg = value;
        stim_q.push_back(s);
    endtask

    // Meter one accepted sample word and queue the words it should produce.
    task automatic meter_sample(input logic [SAMPLE_BITS-1:0] smp, input logic [CH_W-1:0] ch,
                                input logic eob);
        int unsigned     nch;
        int              sval;
        longint unsigned sq;
        longint unsigned rms;
        t_result         w;
        nch  = active_count(chan_cfg);
        sval = {{16{smp[SAMPLE_BITS-1]}}, smp};
        if (ch < nch) begin
            sq = longint'(sval) * longint'(sval);
            if (sval > 0 && sval > int'(peak_hold[ch])) begin
                peak_hold[ch] = sval[PEAK_W-1:0];
            end
            if (sq_sum[ch] > SUM_CEIL - sq) begin
                sq_sum[ch] = SUM_CEIL;
            end else begin
                sq_sum[ch] += sq;
            end
            if ((ch == nch - 1 || eob) && frames_seen < FRAME_CAP) begin
                frames_seen++;
            end
        end
        w = '0;
        w.kind       = KIND_SAMPLE;
        w.sample_out = smp;
        w.last       = !eob;
        level_words.push_back(w);
        samples_metered++;

        // End of block: one report per active channel, then the sums clear.
        if (eob) begin
            for (int unsigned i = 0; i < nch; i++) begin
                rms = 0;
                if (frames_seen != 0) begin
                    rms = root_floor(sq_sum[i] / frames_seen);
                end
                w = '0;
                w.kind           = KIND_REPORT;
                w.report_channel = i[CH_W-1:0];
                w.peak_level     = peak_hold[i];
                w.rms_level      = rms[RMS_W-1:0];
                w.last           = (i == nch - 1);
                level_words.push_back(w);
                sq_sum[i] = 0;
            end
            frames_seen = 0;
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Compare one accepted result word with the oldest expectation.
    task automatic check_word();
        t_result want;
        if (level_words.size() == 0) begin
            flag_mismatch($sformatf("word with nothing expected: kind=%0d sample=%h rms=%0d",
                                    o_kind, o_sample_out, o_rms_level));
        end else begin
            want = level_words.pop_front();
            if (want.kind == KIND_REPORT) begin
                reports_seen++;
            end
            if (o_kind !== want.kind)
                flag_mismatch($sformatf("kind %0d, want %0d", o_kind, want.kind));
            if (o_sample_out !== want.sample_out)
                flag_mismatch($sformatf("sample_out %h, want %h", o_sample_out, want.sample_out));
            if (o_report_channel !== want.report_channel)
                flag_mismatch($sformatf("report_channel %0d, want %0d",
                                        o_report_channel, want.report_channel));
            if (o_peak_level !== want.peak_level)
                flag_mismatch($sformatf("peak_level ch%0d %0d, want %0d",
                                        want.report_channel, o_peak_level, want.peak_level));
            if (o_rms_level !== want.rms_level)
                flag_mismatch($sformatf("rms_level ch%0d %0d, want %0d",
                                        want.report_channel, o_rms_level, want.rms_level));
            if (o_last !== want.last)
                flag_mismatch($sformatf("last %0d, want %0d", o_last, want.last));
        end
    endtask

    // Driver: presents one pending word at a time and, outside calm runs, idles between words at random.
    always @(negedge i_clk) begin : drive_proc
        t_stim                  nxt;
        logic                   n_push;
        logic                   n_cfg;
        logic                   n_pop;
        logic [SAMPLE_BITS-1:0] n_sample;
        logic [CH_W-1:0]        n_channel;
        logic                   n_eob;
        logic [CFG_W-1:0]       n_cfg_data;
        n_push     = push && !push_taken;
        n_cfg      = i_cfg_valid && !cfg_taken;
        n_sample   = i_sample;
        n_channel  = i_channel;
        n_eob      = i_end_of_block;
        n_cfg_data = i_cfg_data;
        n_pop      = 1'b0;
        if (!i_rst_n) begin
            n_push      = 1'b0;
            n_cfg       = 1'b0;
            settle_left = 0;
        end else begin
            if (settle_left != 0) begin
                settle_left--;
            end else if (!n_push && !n_cfg && stim_q.size() != 0) begin
                nxt = stim_q[0];
                unique case (nxt.op)
                    OP_DRAIN: begin
                        // Hold off until every expected word has come back.
                        if (level_words.size() == 0) begin
                            nxt         = stim_q.pop_front();
                            settle_left = SETTLE_CYCLES;
                        end
                    end
                    OP_CONFIG: begin
                        nxt        = stim_q.pop_front();
                        n_cfg      = 1'b1;
                        n_cfg_data = nxt.cfg;
                    end
                    default: begin
                        calm_run = nxt.calm;
                        if (nxt.calm || $urandom_range(99) >= 27) begin
                            nxt       = stim_q.pop_front();
                            n_push    = 1'b1;
                            n_sample  = nxt.sample;
                            n_channel = nxt.channel;
                            n_eob     = nxt.eob;
                        end
                    end
                endcase
            end
            n_pop = calm_run || ($urandom_range(99) >= 27);
        end
        push           <= n_push;
        i_sample       <= n_sample;
        i_channel      <= n_channel;
        i_end_of_block <= n_eob;
        i_cfg_valid    <= n_cfg;
        i_cfg_data     <= n_cfg_data;
        pop            <= n_pop;
    end

    // Monitor: records handshakes, runs the predictor and checks result words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push_taken <= 1'b0;
            cfg_taken  <= 1'b0;
        end else begin
            push_taken <= push && !full;
            cfg_taken  <= i_cfg_valid && o_cfg_ready;
            if (push && !full) begin
                meter_sample(i_sample, i_channel, i_end_of_block);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                chan_cfg = i_cfg_data;
                cfg_writes++;
            end
            if (pop && !empty) begin
                check_word();
            end
        end
    end

    // Watchdog: too many cycles without any handshake ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stim_proc
        logic [SAMPLE_BITS-1:0] pattern[8];
        logic [CFG_W-1:0]       cfg_val;
        int unsigned            nch;
        int unsigned            frames;
        int                     made;
        logic                   calm;

        for (int i = 0; i < METER_CHANNELS; i++) begin
            peak_hold[i] = '0;
            sq_sum[i]    = 0;
        end

        // Directed: extremes at the reset channel count of two, a stray channel,
        // then an end of block on a stray channel with no frames counted.
        queue_sample(16'h7FFF, 0, 1'b0, 1'b0);
        queue_sample(16'h8000, 1, 1'b0, 1'b0);
        queue_sample(16'h0001, 0, 1'b0, 1'b0);
        queue_sample(16'hFFFF, 1, 1'b0, 1'b0);
        queue_sample(16'h0000, 5, 1'b0, 1'b0);
        queue_sample(16'h1234, 0, 1'b1, 1'b0);
        queue_sample(16'h4000, 7, 1'b1, 1'b0);

        // A count of zero acts as one channel.
        queue_config(4'd0);
        queue_sample(16'h8000, 0, 1'b0, 1'b0);
        queue_sample(16'h7FFF, 0, 1'b1, 1'b0);

        // The largest count clamps to eight channels.
        pattern = '{16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA,
                    16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0};
        queue_config(4'd15);
        for (int c = 0; c < METER_CHANNELS; c++) begin
            queue_sample(pattern[c], c, c == METER_CHANNELS - 1, 1'b0);
        end

        // One above the maximum, and an end of block on a middle channel.
        queue_config(4'd9);
        queue_sample(16'h0100, 3, 1'b1, 1'b0);

        // One long single-channel block of full-scale words sent without idling.
        queue_config(4'd1);
        for (int k = 0; k < LONG_LENGTH; k++) begin
            queue_sample(16'h8000, 0, k == LONG_LENGTH - 1, 1'b1);
        end

        // Random phases: mostly well-formed frames, with stray words mixed in.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: cfg_val = 4'd8;
                1: cfg_val = 4'd3;
                2: cfg_val = 4'd15;
                3: cfg_val = 4'd1;
                4: cfg_val = 4'd0;
                default: cfg_val = CFG_W'($urandom_range(15));
            endcase
            queue_config(cfg_val);
            nch  = active_count(cfg_val);
            calm = (ph == 2);
            made = 0;
            while (made < PHASE_ITEMS) begin
                if ($urandom_range(99) < 15) begin
                    queue_sample(rand_sample(), $urandom_range(7), $urandom_range(5) == 0, calm);
                    made++;
                end else begin
                    frames = ($urandom_range(7) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
                    for (int f = 0; f < frames; f++) begin
                        for (int c = 0; c < nch; c++) begin
                            queue_sample(rand_sample(), c, f == frames - 1 && c == nch - 1, calm);
                            made++;
                        end
                    end
                end
            end
        end

        // Synchronous reset, released on a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || push || i_cfg_valid) begin
            @(posedge i_clk);
        end
        while (level_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (level_words.size() != 0) begin
            flag_mismatch($sformatf("%0d expected words never came", level_words.size()));
        end

        $display("Covered %0d sample words, %0d level reports and %0d channel-count writes,",
                 samples_metered, reports_seen, cfg_writes);
        $display("including a %0d-sample full-scale block sent without idling; %0d mismatches.",
                 LONG_LENGTH, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
